[sv/ptrt_pkg.sv]
// Shared types and constants of the periodic task release table.
package ptrt_pkg;

	localparam int KIND_W      = 3;
	localparam int IDX_W       = 3;
	localparam int TAG_W       = 8;
	localparam int DELAY_W     = 32;
	localparam int PERIOD_W    = 31;
	localparam int RUNS_W      = 8;
	localparam int SLOT_OUT_W  = 4;
	localparam int RESULTS_MAX = 8;
	localparam int REL_CNT_W   = 4;

	localparam logic [RUNS_W-1:0]         RUNS_MAX  = 8'hFF;
	localparam logic signed [DELAY_W-1:0] DELAY_MIN = 32'sh8000_0000;

	// Operation status reported in every result word.
	localparam logic OP_DONE  = 1'b0;
	localparam logic OP_ERROR = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK     = 3'd0,
		KIND_ADD      = 3'd1,
		KIND_DELETE   = 3'd2,
		KIND_MODIFY   = 3'd3,
		KIND_DISPATCH = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_RD,
		ST_EX,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [TAG_W-1:0]         tag;
		logic signed [DELAY_W-1:0] delay;
		logic [PERIOD_W-1:0]      period;
		logic [RUNS_W-1:0]        runs;
	} slot_entry_t;

	typedef struct packed {
		logic                  op_status;
		logic [SLOT_OUT_W-1:0] slot_index;
		logic                  run_valid;
		logic [TAG_W-1:0]      run_tag;
	} rsp_word_t;

endpackage

[sv/ptrt_cmd_if.sv]
// Command channel: one word per table operation.
interface ptrt_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [ptrt_pkg::KIND_W-1:0]       kind;
	logic [ptrt_pkg::IDX_W-1:0]        task_index;
	logic [ptrt_pkg::TAG_W-1:0]        task_tag;
	logic [ptrt_pkg::PERIOD_W-1:0]     start_delay;
	logic [ptrt_pkg::PERIOD_W-1:0]     period_ticks;

	modport source (output valid, kind, task_index, task_tag, start_delay, period_ticks,
		input ready);
	modport sink (input valid, kind, task_index, task_tag, start_delay, period_ticks,
		output ready);
endinterface

[sv/ptrt_rsp_if.sv]
// Response channel: status and task release words.
interface ptrt_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              op_status;
	logic [ptrt_pkg::SLOT_OUT_W-1:0]   slot_index;
	logic                              run_valid;
	logic [ptrt_pkg::TAG_W-1:0]        run_tag;
	logic                              error_latched;
	logic                              last;

	modport source (output valid, op_status, slot_index, run_valid, run_tag, error_latched,
		last, input ready);
	modport sink (input valid, op_status, slot_index, run_valid, run_tag, error_latched,
		last, output ready);
endinterface

[sv/periodic_task_release_table.sv]
// Top level of the periodic task release table: sequencer, valid bits and response register.
//
// Usage: commands arrive on cmd (tick, add, delete, modify period, dispatch), one word
// per operation; results leave on rsp, one word per result, the final word of each
// command marked by last. Dispatch gives one word per released slot (at most eight),
// lowest slot first, or a single empty word when no slot is ready.
// Sequencing: cmd.ready is high only while the sequencer is idle.
// Tick and dispatch walk the slot memory slot by slot (read, then update through the
// shared slot unit and write back). Add scans the valid bits one slot per cycle.
// Modify period reads, writes back and responds; delete clears the valid bit and
// responds. The single memory port pair sets this sequencing of reads and writes.
// Reset: the valid bits clear at once, so every slot reads as empty with no clearing
// pass; the sticky error flag clears too. Memory contents of empty slots are ignored.
// Stall: results sit in a one-word output register; while it is full and rsp.ready is
// low, the sequencer holds at the next result and the table does not change further.
module periodic_task_release_table #(
	parameter int TASK_SLOTS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	ptrt_cmd_if.sink      cmd,
	ptrt_rsp_if.source    rsp
);

	localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TASK_SLOTS - 1);
	localparam logic [ptrt_pkg::REL_CNT_W-1:0] REL_LAST =
		ptrt_pkg::REL_CNT_W'(ptrt_pkg::RESULTS_MAX - 1);
	localparam logic [ptrt_pkg::SLOT_OUT_W-1:0] SLOT_FULL =
		ptrt_pkg::SLOT_OUT_W'(TASK_SLOTS);

	// Sequencer state
	ptrt_pkg::state_t                     state_q, state_d;
	logic [SLOT_W-1:0]                    idx_q, idx_d;
	logic [ptrt_pkg::REL_CNT_W-1:0]       cnt_q, cnt_d;
	logic                                 have_q, have_d;
	ptrt_pkg::rsp_word_t                  pend_q, pend_d;
	logic                                 sticky_q, sticky_d;
	logic [TASK_SLOTS-1:0]                valid_q;

	// Latched command
	ptrt_pkg::kind_t                      kind_q;
	logic [ptrt_pkg::TAG_W-1:0]           tag_q;
	logic [ptrt_pkg::PERIOD_W-1:0]        sdelay_q;
	logic [ptrt_pkg::PERIOD_W-1:0]        per_q;

	// Output register
	logic                                 out_vld_q;
	ptrt_pkg::rsp_word_t                  out_q;
	logic                                 out_err_q;
	logic                                 out_last_q;

	// Control
	logic                                 accept;
	logic                                 can_push;
	logic                                 push;
	logic                                 push_last;
	logic                                 mem_we;
	logic                                 mem_re;
	logic                                 vld_we;
	logic                                 vld_val;
	logic [SLOT_W-1:0]                    vld_addr;
	logic                                 cmd_in_range;
	logic [SLOT_W-1:0]                    cmd_slot;
	logic [SLOT_W+3:0]                    slot_ext;
	ptrt_pkg::kind_t                      cmd_kind;
	ptrt_pkg::slot_entry_t                mem_rdata;
	ptrt_pkg::slot_entry_t                cur_entry;
	ptrt_pkg::slot_entry_t                nxt_entry;

	assign cmd_kind     = ptrt_pkg::kind_t'(cmd.kind);
	assign cmd_in_range = (32'(cmd.task_index) < 32'(TASK_SLOTS));
	assign cmd_slot     = SLOT_W'(cmd.task_index);
	assign slot_ext     = {4'b0000, idx_q};
	assign cmd.ready    = (state_q == ptrt_pkg::ST_IDLE);
	assign accept       = cmd.valid && cmd.ready;
	assign can_push     = !out_vld_q || rsp.ready;

	// Empty slots read as all zero whatever the memory holds.
	assign cur_entry = valid_q[idx_q] ? mem_rdata : '0;

	ptrt_slot_mem #(
		.DEPTH (TASK_SLOTS),
		.AW    (SLOT_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (idx_q),
		.wdata (nxt_entry),
		.re    (mem_re),
		.raddr (idx_q),
		.rdata (mem_rdata)
	);

	ptrt_slot_alu u_alu (
		.op           (kind_q),
		.cur          (cur_entry),
		.task_tag     (tag_q),
		.start_delay  (sdelay_q),
		.period_ticks (per_q),
		.nxt          (nxt_entry)
	);

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		cnt_d     = cnt_q;
		have_d    = have_q;
		pend_d    = pend_q;
		sticky_d  = sticky_q;
		push      = 1'b0;
		push_last = 1'b1;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		vld_we    = 1'b0;
		vld_val   = 1'b0;
		vld_addr  = idx_q;

		unique case (state_q)
			ptrt_pkg::ST_IDLE: begin
				if (accept) begin
					pend_d = '0;
					have_d = 1'b0;
					cnt_d  = '0;
					idx_d  = '0;
					unique case (cmd_kind) inside
						ptrt_pkg::KIND_TICK, ptrt_pkg::KIND_DISPATCH: begin
							state_d = ptrt_pkg::ST_RD;
						end
						ptrt_pkg::KIND_ADD: begin
							state_d = ptrt_pkg::ST_ADD;
						end
						ptrt_pkg::KIND_DELETE: begin
							// Clear the slot; an empty slot also raises the sticky error.
							state_d = ptrt_pkg::ST_FIN;
							if (cmd_in_range) begin
								vld_we   = 1'b1;
								vld_addr = cmd_slot;
								if (!valid_q[cmd_slot]) begin
									sticky_d         = 1'b1;
									pend_d.op_status = ptrt_pkg::OP_ERROR;
								end
							end else begin
								pend_d.op_status = ptrt_pkg::OP_ERROR;
							end
						end
						ptrt_pkg::KIND_MODIFY: begin
							if (cmd_in_range && valid_q[cmd_slot]) begin
								idx_d   = cmd_slot;
								state_d = ptrt_pkg::ST_RD;
							end else begin
								pend_d.op_status = ptrt_pkg::OP_ERROR;
								state_d          = ptrt_pkg::ST_FIN;
							end
						end
						default: begin
							pend_d.op_status = ptrt_pkg::OP_ERROR;
							state_d          = ptrt_pkg::ST_FIN;
						end
					endcase
				end
			end

			ptrt_pkg::ST_ADD: begin
				// Take the first free slot, or report a full table.
				if (!valid_q[idx_q]) begin
					mem_we            = 1'b1;
					vld_we            = 1'b1;
					vld_val           = 1'b1;
					pend_d.slot_index = slot_ext[ptrt_pkg::SLOT_OUT_W-1:0];
					state_d           = ptrt_pkg::ST_FIN;
				end else if (idx_q == SLOT_LAST) begin
					sticky_d          = 1'b1;
					pend_d.op_status  = ptrt_pkg::OP_ERROR;
					pend_d.slot_index = SLOT_FULL;
					state_d           = ptrt_pkg::ST_FIN;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end

			ptrt_pkg::ST_RD: begin
				mem_re  = 1'b1;
				state_d = ptrt_pkg::ST_EX;
			end

			ptrt_pkg::ST_EX: begin
				case (kind_q)
					ptrt_pkg::KIND_TICK: begin
						mem_we = valid_q[idx_q];
						if (idx_q == SLOT_LAST) begin
							state_d = ptrt_pkg::ST_FIN;
						end else begin
							idx_d   = idx_q + 1'b1;
							state_d = ptrt_pkg::ST_RD;
						end
					end
					ptrt_pkg::KIND_MODIFY: begin
						mem_we  = 1'b1;
						state_d = ptrt_pkg::ST_FIN;
					end
					ptrt_pkg::KIND_DISPATCH: begin
						if (cur_entry.runs == '0) begin
							if (idx_q == SLOT_LAST) begin
								state_d = ptrt_pkg::ST_FIN;
							end else begin
								idx_d   = idx_q + 1'b1;
								state_d = ptrt_pkg::ST_RD;
							end
						end else if (!have_q || can_push) begin
							// Flush the previous release, then hold this one as pending.
							push      = have_q;
							push_last = 1'b0;
							if (cur_entry.period == '0) begin
								vld_we = 1'b1;
							end else begin
								mem_we = 1'b1;
							end
							pend_d.op_status  = ptrt_pkg::OP_DONE;
							pend_d.slot_index = slot_ext[ptrt_pkg::SLOT_OUT_W-1:0];
							pend_d.run_valid  = 1'b1;
							pend_d.run_tag    = cur_entry.tag;
							have_d            = 1'b1;
							cnt_d             = cnt_q + 1'b1;
							if (cnt_q == REL_LAST || idx_q == SLOT_LAST) begin
								state_d = ptrt_pkg::ST_FIN;
							end else begin
								idx_d   = idx_q + 1'b1;
								state_d = ptrt_pkg::ST_RD;
							end
						end
					end
					default: begin
						state_d = ptrt_pkg::ST_FIN;
					end
				endcase
			end

			ptrt_pkg::ST_FIN: begin
				if (can_push) begin
					push    = 1'b1;
					state_d = ptrt_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = ptrt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ptrt_pkg::ST_IDLE;
			idx_q    <= '0;
			cnt_q    <= '0;
			have_q   <= 1'b0;
			sticky_q <= 1'b0;
			kind_q   <= ptrt_pkg::KIND_TICK;
		end else begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			cnt_q    <= cnt_d;
			have_q   <= have_d;
			sticky_q <= sticky_d;
			if (accept) begin
				kind_q <= cmd_kind;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		if (accept) begin
			tag_q    <= cmd.task_tag;
			sdelay_q <= cmd.start_delay;
			per_q    <= cmd.period_ticks;
		end
	end

	// Valid bits: clear on reset, set on add, drop on delete or one-shot release.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (vld_we) begin
			valid_q[vld_addr] <= vld_val;
		end
	end

	// Output register: load on push, drop when the receiver takes the word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (push) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q      <= pend_q;
			out_err_q  <= sticky_q;
			out_last_q <= push_last;
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.op_status     = out_q.op_status;
	assign rsp.slot_index    = out_q.slot_index;
	assign rsp.run_valid     = out_q.run_valid;
	assign rsp.run_tag       = out_q.run_tag;
	assign rsp.error_latched = out_err_q;
	assign rsp.last          = out_last_q;

endmodule

[sv/ptrt_slot_mem.sv]
// Slot entry storage: one write port, one read port with registered read data.
module ptrt_slot_mem #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  ptrt_pkg::slot_entry_t   wdata,
	input  logic                    re,
	input  logic [AW-1:0]           raddr,
	output ptrt_pkg::slot_entry_t   rdata
);

	ptrt_pkg::slot_entry_t mem_q [DEPTH];
	ptrt_pkg::slot_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/ptrt_slot_alu.sv]
// Shared slot update unit: tick countdown, release, period change and fresh entry.
module ptrt_slot_alu (
	input  ptrt_pkg::kind_t                 op,
	input  ptrt_pkg::slot_entry_t           cur,
	input  logic [ptrt_pkg::TAG_W-1:0]      task_tag,
	input  logic [ptrt_pkg::PERIOD_W-1:0]   start_delay,
	input  logic [ptrt_pkg::PERIOD_W-1:0]   period_ticks,
	output ptrt_pkg::slot_entry_t           nxt
);

	logic signed [ptrt_pkg::DELAY_W-1:0] dec;
	logic                                expired;

	// Count down, saturate at the most negative delay.
	assign dec     = (cur.delay == ptrt_pkg::DELAY_MIN) ? cur.delay : cur.delay - 32'sd1;
	assign expired = dec[ptrt_pkg::DELAY_W-1] || (dec == '0);

	always_comb begin
		nxt = cur;
		unique case (op)
			ptrt_pkg::KIND_TICK: begin
				nxt.delay = dec;
				if (expired) begin
					if (cur.runs != ptrt_pkg::RUNS_MAX) begin
						nxt.runs = cur.runs + 8'd1;
					end
					if (cur.period != '0) begin
						nxt.delay = {1'b0, cur.period};
					end
				end
			end
			ptrt_pkg::KIND_ADD: begin
				nxt.tag    = task_tag;
				nxt.delay  = {1'b0, start_delay};
				nxt.period = period_ticks;
				nxt.runs   = '0;
			end
			ptrt_pkg::KIND_MODIFY: begin
				nxt.period = period_ticks;
			end
			ptrt_pkg::KIND_DISPATCH: begin
				nxt.runs = cur.runs - 8'd1;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule
